// ===== sv/prq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the priority run queue.
// No dependencies; every other file imports this package.
package prq_pkg;

  localparam int unsigned PRQ_SLOTS = 16;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned ID_W   = 16;
  localparam int unsigned PRIO_W = 16;
  localparam int unsigned SLC_W  = 16;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned OCC_W  = 5;

  localparam logic [SLC_W-1:0] MAX_SLICE_RST = 16'd5;

  // operation codes
  localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
  localparam logic [OP_W-1:0] OP_PICK = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture the input word, restart the scan
    logic scan;    // read the slot at the scan index and advance
    logic commit;  // update the table and the result register
  } prq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;  // scan index sits on the last slot
  } prq_stat_t;

endpackage

// ===== sv/prq_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the priority run queue: accept, slot scan, drain, commit, output valid.
// Depends on prq_pkg.
module prq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  prq_pkg::prq_stat_t  stat_i,
  output prq_pkg::prq_cmd_t   cmd_o
);
  import prq_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last read word is compared in this cycle
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        // hold until the result register can take a new word
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== sv/prq_datapath.sv =====
`timescale 1ns / 1ps
// Slot table, scan compare and result register of the priority run queue.
// Depends on prq_pkg; driven by prq_ctrl commands.
module prq_datapath #(
  parameter int unsigned SLOTS = prq_pkg::PRQ_SLOTS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  prq_pkg::prq_cmd_t             cmd_i,
  output prq_pkg::prq_stat_t            stat_o,
  input  logic                          cfg_we_i,
  input  logic [prq_pkg::SLC_W-1:0]     cfg_wdata_i,
  input  logic [prq_pkg::OP_W-1:0]      operation_i,
  input  logic [prq_pkg::ID_W-1:0]      proc_id_i,
  input  logic [prq_pkg::PRIO_W-1:0]    prio_in_i,
  input  logic [prq_pkg::SLC_W-1:0]     slice_in_i,
  output logic [prq_pkg::ST_W-1:0]      status_o,
  output logic [prq_pkg::ID_W-1:0]      chosen_id_o,
  output logic [prq_pkg::PRIO_W-1:0]    chosen_prio_o,
  output logic [prq_pkg::SLC_W-1:0]     granted_slice_o,
  output logic [prq_pkg::OCC_W-1:0]     occupancy_o
);
  import prq_pkg::*;

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);

  // slot contents, valid only where the used bit is set
  logic [ID_W-1:0]   id_mem   [SLOTS];
  logic [PRIO_W-1:0] prio_mem [SLOTS];
  logic [SLOTS-1:0]  used_q, used_d;
  logic [CW-1:0]     count_q, count_d;
  logic [SLC_W-1:0]  max_slice_q;

  logic [OP_W-1:0]   op_q;
  logic [ID_W-1:0]   id_q;
  logic [PRIO_W-1:0] prio_q;
  logic [SLC_W-1:0]  slice_q;

  logic [IW-1:0]     idx_q;
  logic              rd_vld_q;
  logic [IW-1:0]     rd_idx_q;
  logic [ID_W-1:0]   rd_id_q;
  logic [PRIO_W-1:0] rd_prio_q;

  logic              hit_q, hit_d;
  logic [IW-1:0]     hit_idx_q, hit_idx_d;
  logic [ID_W-1:0]   best_id_q, best_id_d;
  logic [PRIO_W-1:0] best_prio_q, best_prio_d;

  logic [ST_W-1:0]   status_q, status_d;
  logic [ID_W-1:0]   cid_q, cid_d;
  logic [PRIO_W-1:0] cprio_q, cprio_d;
  logic [SLC_W-1:0]  granted_q, granted_d;
  logic [OCC_W-1:0]  occ_q;

  logic              rd_used;
  logic              take;

  assign stat_o.scan_last = (idx_q == IW'(SLOTS - 1));
  assign rd_used          = used_q[rd_idx_q];

  // compare the word read in the previous cycle
  always_comb begin
    take = 1'b0;
    case (op_q)
      OP_ENQ:  take = !rd_used && !hit_q;
      OP_DEQ:  take = rd_used && (rd_id_q == id_q) && !hit_q;
      OP_PICK: take = rd_used && (!hit_q || (rd_prio_q < best_prio_q));
      default: take = 1'b0;
    endcase
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    best_id_d   = best_id_q;
    best_prio_d = best_prio_q;
    if (cmd_i.load) begin
      hit_d = 1'b0;
    end else if (rd_vld_q && take) begin
      hit_d       = 1'b1;
      hit_idx_d   = rd_idx_q;
      best_id_d   = rd_id_q;
      best_prio_d = rd_prio_q;
    end
  end

  // table update and result word
  always_comb begin
    used_d    = used_q;
    count_d   = count_q;
    status_d  = ST_OK;
    cid_d     = id_q;
    cprio_d   = '0;
    granted_d = '0;
    case (op_q)
      OP_ENQ: begin
        if (!hit_q) begin
          status_d = ST_FULL;
        end else begin
          used_d[hit_idx_q] = 1'b1;
          count_d           = count_q + CW'(1);
          granted_d = (slice_q == '0 || slice_q > max_slice_q) ? max_slice_q : slice_q;
        end
      end
      OP_DEQ: begin
        if (!hit_q) begin
          status_d = ST_NOTFOUND;
        end else begin
          used_d[hit_idx_q] = 1'b0;
          if (count_q != '0) begin
            count_d = count_q - CW'(1);
          end
        end
      end
      OP_PICK: begin
        if (!hit_q) begin
          status_d = ST_EMPTY;
          cid_d    = '0;
        end else begin
          cid_d   = best_id_q;
          cprio_d = best_prio_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      count_q     <= '0;
      max_slice_q <= MAX_SLICE_RST;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_slice_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (cmd_i.scan) begin
        idx_q <= idx_q + IW'(1);
      end
      rd_vld_q <= cmd_i.scan;
      hit_q    <= hit_d;
      if (cmd_i.commit) begin
        used_q  <= used_d;
        count_q <= count_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= operation_i;
      id_q    <= proc_id_i;
      prio_q  <= prio_in_i;
      slice_q <= slice_in_i;
    end
    if (cmd_i.scan) begin
      rd_idx_q <= idx_q;
    end
    hit_idx_q   <= hit_idx_d;
    best_id_q   <= best_id_d;
    best_prio_q <= best_prio_d;
    if (cmd_i.commit) begin
      status_q  <= status_d;
      cid_q     <= cid_d;
      cprio_q   <= cprio_d;
      granted_q <= granted_d;
      occ_q     <= OCC_W'(count_d);
    end
  end

  // slot memory: one read port for the scan, one write port at commit
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      rd_id_q   <= id_mem[idx_q];
      rd_prio_q <= prio_mem[idx_q];
    end
    if (cmd_i.commit && op_q == OP_ENQ && hit_q) begin
      id_mem[hit_idx_q]   <= id_q;
      prio_mem[hit_idx_q] <= prio_q;
    end
  end

  assign status_o        = status_q;
  assign chosen_id_o     = cid_q;
  assign chosen_prio_o   = cprio_q;
  assign granted_slice_o = granted_q;
  assign occupancy_o     = occ_q;

endmodule

// ===== sv/priority_run_queue.sv =====
`timescale 1ns / 1ps
// Top level of the priority run queue: controller plus datapath.
// Depends on prq_pkg, prq_ctrl and prq_datapath.
//
// A run queue of SLOTS process slots taking one word at a time: enqueue (lowest
// free slot, slice clamped to max_slice), dequeue by id (lowest matching slot),
// pick (smallest priority, lowest slot on ties, nothing removed). Every word
// scans the whole slot table through one memory read port, one slot per cycle,
// and its commit waits while the previous result is still stalled. The result
// register lets the next word be accepted while a result waits. No clearing
// pass after reset.
module priority_run_queue #(
  parameter int unsigned SLOTS = prq_pkg::PRQ_SLOTS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [prq_pkg::OP_W-1:0]      operation_i,
  input  logic [prq_pkg::ID_W-1:0]      proc_id_i,
  input  logic [prq_pkg::PRIO_W-1:0]    prio_in_i,
  input  logic [prq_pkg::SLC_W-1:0]     slice_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [prq_pkg::ST_W-1:0]      status_o,
  output logic [prq_pkg::ID_W-1:0]      chosen_id_o,
  output logic [prq_pkg::PRIO_W-1:0]    chosen_prio_o,
  output logic [prq_pkg::SLC_W-1:0]     granted_slice_o,
  output logic [prq_pkg::OCC_W-1:0]     occupancy_o,
  input  logic                          cfg_we_i,
  input  logic [prq_pkg::SLC_W-1:0]     cfg_wdata_i
);
  import prq_pkg::*;

  prq_cmd_t  cmd;
  prq_stat_t stat;

  prq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  prq_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .operation_i     (operation_i),
    .proc_id_i       (proc_id_i),
    .prio_in_i       (prio_in_i),
    .slice_in_i      (slice_in_i),
    .status_o        (status_o),
    .chosen_id_o     (chosen_id_o),
    .chosen_prio_o   (chosen_prio_o),
    .granted_slice_o (granted_slice_o),
    .occupancy_o     (occupancy_o)
  );

  // an accepted word keeps the input side busy for its scan
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted again during scan");

  a_full_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_FULL) |-> (occupancy_o == OCC_W'(SLOTS)))
    else $error("table full reported below capacity");

  a_empty_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_EMPTY) |-> (occupancy_o == '0 && chosen_id_o == '0))
    else $error("empty pick with processes queued");

  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && granted_slice_o != '0) |-> (status_o == ST_OK))
    else $error("slice granted on a failed word");

endmodule
